/* sv/wgcs_pkg.sv */
// Package for the wrapped grid cell store: request and command codes,
// the command record passed from front to back, and coordinate helpers.
// No dependencies.
`default_nettype none

package wgcs_pkg;

  localparam logic [7:0] DEFAULT_SIZE = 8'd100;
  localparam logic [7:0] MIN_SIZE = 8'd10;

  localparam int CMDQ_DEPTH = 2;

  // Configuration register indexes.
  localparam logic REG_GRID_WIDTH = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    KIND_GET         = 4'd0,
    KIND_SET         = 4'd1,
    KIND_CLEAR       = 4'd2,
    KIND_EMPTY_TEST  = 4'd3,
    KIND_POINT_WRITE = 4'd4,
    KIND_DIR_WRITE   = 4'd5,
    KIND_MOVE_POINT  = 4'd6,
    KIND_MOVE_DIR    = 4'd7,
    KIND_DIR_TEST    = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_GET,
    OP_WRITE,
    OP_CLEAR,
    OP_TEST,
    OP_MOVE_PT,
    OP_MOVE_DIR
  } op_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_ISSUE,
    BK_DATA
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  src_x;
    logic [7:0]  src_y;
    logic [7:0]  dst_x;
    logic [7:0]  dst_y;
    logic [1:0]  cell_kind;
    logic [31:0] payload;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] payload;
    logic        free;
    logic        wrote;
  } res_t;

  function automatic logic [7:0] size_sel(input logic [7:0] v, input logic [10:0] maxv);
    if (v < MIN_SIZE) begin
      return DEFAULT_SIZE;
    end else if ({3'b000, v} > maxv) begin
      return maxv[7:0];
    end else begin
      return v;
    end
  endfunction

  function automatic logic signed [9:0] dir_dx(input logic [2:0] dir);
    case (dir)
      3'd0, 3'd1, 3'd7: return 10'sd1;
      3'd3, 3'd4, 3'd5: return -10'sd1;
      default:          return 10'sd0;
    endcase
  endfunction

  // Rows grow downward, so north is a step of minus one.
  function automatic logic signed [9:0] dir_dy(input logic [2:0] dir);
    case (dir)
      3'd1, 3'd2, 3'd3: return -10'sd1;
      3'd5, 3'd6, 3'd7: return 10'sd1;
      default:          return 10'sd0;
    endcase
  endfunction

  function automatic logic span_ok(input logic signed [9:0] v, input logic [7:0] lim);
    return !v[9] && (unsigned'(v) < {2'b00, lim});
  endfunction

  // Columns wrap once: below zero goes to the last column, past the end to zero.
  function automatic logic [7:0] wrap_col(input logic signed [9:0] x, input logic [7:0] gw);
    if (x[9]) begin
      return gw - 8'd1;
    end else if (unsigned'(x) >= {2'b00, gw}) begin
      return 8'd0;
    end else begin
      return x[7:0];
    end
  endfunction

endpackage

`default_nettype wire

/* sv/wgcs_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module wgcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/wgcs_front.sv */
// Request classifier: wraps columns, checks rows and folds every request into
// a command for the back end. Uses wgcs_pkg.
`default_nettype none

module wgcs_front (
  input  logic [3:0]          kind,
  input  logic signed [8:0]   x_coord,
  input  logic signed [8:0]   y_coord,
  input  logic [2:0]          direction,
  input  logic [1:0]          cell_kind,
  input  logic [31:0]         payload,
  input  logic signed [8:0]   target_x,
  input  logic signed [8:0]   target_y,
  input  logic [7:0]          grid_width,
  input  logic [7:0]          grid_height,
  output wgcs_pkg::cmd_t      cmd
);

  logic signed [9:0] xe, ye, tye, txe, nx_raw, ny_raw;
  logic [7:0] wx, nx, twx;
  logic src_in, y_ok, nb_ok, ty_ok;

  always_comb begin
    xe = $signed({x_coord[8], x_coord});
    ye = $signed({y_coord[8], y_coord});
    txe = $signed({target_x[8], target_x});
    tye = $signed({target_y[8], target_y});
    nx_raw = xe + wgcs_pkg::dir_dx(direction);
    ny_raw = ye + wgcs_pkg::dir_dy(direction);

    wx = wgcs_pkg::wrap_col(xe, grid_width);
    nx = wgcs_pkg::wrap_col(nx_raw, grid_width);
    twx = wgcs_pkg::wrap_col(txe, grid_width);

    y_ok = wgcs_pkg::span_ok(ye, grid_height);
    nb_ok = wgcs_pkg::span_ok(ny_raw, grid_height);
    ty_ok = wgcs_pkg::span_ok(tye, grid_height);
    src_in = wgcs_pkg::span_ok(xe, grid_width) && y_ok;

    // Any request that cannot touch a cell becomes OP_NONE, whose result is all zero.
    cmd.op = wgcs_pkg::OP_NONE;
    cmd.src_x = xe[7:0];
    cmd.src_y = ye[7:0];
    cmd.dst_x = xe[7:0];
    cmd.dst_y = ye[7:0];
    cmd.cell_kind = cell_kind;
    cmd.payload = payload;

    case (kind)
      wgcs_pkg::KIND_GET: begin
        if (src_in) cmd.op = wgcs_pkg::OP_GET;
      end
      wgcs_pkg::KIND_SET: begin
        if (src_in && (cell_kind != 2'd0)) cmd.op = wgcs_pkg::OP_WRITE;
      end
      wgcs_pkg::KIND_CLEAR: begin
        if (src_in) cmd.op = wgcs_pkg::OP_CLEAR;
      end
      wgcs_pkg::KIND_EMPTY_TEST: begin
        if (src_in) cmd.op = wgcs_pkg::OP_TEST;
      end
      wgcs_pkg::KIND_POINT_WRITE: begin
        if (y_ok) cmd.op = wgcs_pkg::OP_WRITE;
        cmd.dst_x = wx;
      end
      wgcs_pkg::KIND_DIR_WRITE: begin
        if (nb_ok) cmd.op = wgcs_pkg::OP_WRITE;
        cmd.dst_x = nx;
        cmd.dst_y = ny_raw[7:0];
      end
      wgcs_pkg::KIND_MOVE_POINT: begin
        // An out-of-range source reads as empty, so nothing would be copied.
        if (ty_ok && src_in) cmd.op = wgcs_pkg::OP_MOVE_PT;
        cmd.dst_x = twx;
        cmd.dst_y = tye[7:0];
      end
      wgcs_pkg::KIND_MOVE_DIR: begin
        if (src_in && nb_ok) cmd.op = wgcs_pkg::OP_MOVE_DIR;
        cmd.dst_x = nx;
        cmd.dst_y = ny_raw[7:0];
      end
      wgcs_pkg::KIND_DIR_TEST: begin
        if (nb_ok) cmd.op = wgcs_pkg::OP_TEST;
        cmd.dst_x = nx;
        cmd.dst_y = ny_raw[7:0];
      end
      default: begin
        cmd.op = wgcs_pkg::OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/wgcs_cmd_fifo.sv */
// Two-entry command queue between the classifier and the cell sequencer.
// Uses wgcs_pkg.
`default_nettype none

module wgcs_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wgcs_pkg::cmd_t push_cmd,
  input  logic           pop,
  output wgcs_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);

  localparam int PW = (wgcs_pkg::CMDQ_DEPTH > 1) ? $clog2(wgcs_pkg::CMDQ_DEPTH) : 1;

  wgcs_pkg::cmd_t slots [wgcs_pkg::CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign head = slots[rd_ptr];
  assign full = (count == (PW + 1)'(wgcs_pkg::CMDQ_DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(wgcs_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(wgcs_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/wgcs_back.sv */
// Cell sequencer: owns the type and payload memories, clears them after reset,
// carries out commands and holds the result register. Uses wgcs_pkg, wgcs_ram.
`default_nettype none

module wgcs_back #(
  parameter int MAX_WIDTH = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  wgcs_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     read_kind,
  output logic [31:0]    read_payload,
  output logic           is_free,
  output logic           wrote
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(CELLS);
  // Wide enough for any column and row below 256 and for the cell count itself.
  localparam int LW = $clog2(255 * MAX_HEIGHT + 256 + CELLS);
  localparam logic [LW-1:0] CELLS_L = LW'(CELLS);

  wgcs_pkg::back_state_e state, state_next;
  wgcs_pkg::op_e op;
  logic [1:0]    ck;
  logic [31:0]   pl;
  logic [LW-1:0] src_lin, src_lin_next, dst_lin, dst_lin_next;
  logic [LW-1:0] head_src_lin, head_dst_lin;
  logic          phase, phase_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic          src_used, dst_used;
  logic          src_hi, dst_hi;

  logic [AW-1:0] ram_raddr, ram_waddr;
  logic          t_we, p_we;
  logic [1:0]    t_wdata, t_rdata;
  logic [31:0]   p_wdata, p_rdata;

  logic             res_load;
  wgcs_pkg::res_t   res_next, res;

  wgcs_ram #(.WIDTH(2), .DEPTH(CELLS)) u_type_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (ram_waddr),
    .wdata (t_wdata),
    .raddr (ram_raddr),
    .rdata (t_rdata)
  );

  wgcs_ram #(.WIDTH(32), .DEPTH(CELLS)) u_payload_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (ram_waddr),
    .wdata (p_wdata),
    .raddr (ram_raddr),
    .rdata (p_rdata)
  );

  assign head_src_lin = LW'(q_head.src_x) * LW'(MAX_HEIGHT) + LW'(q_head.src_y);
  assign head_dst_lin = LW'(q_head.dst_x) * LW'(MAX_HEIGHT) + LW'(q_head.dst_y);
  // Only the addresses a command actually touches are folded.
  assign src_used = (op == wgcs_pkg::OP_GET) || (op == wgcs_pkg::OP_MOVE_PT) ||
                    (op == wgcs_pkg::OP_MOVE_DIR);
  assign dst_used = (op != wgcs_pkg::OP_NONE) && (op != wgcs_pkg::OP_GET);
  assign src_hi = src_used && (src_lin >= CELLS_L);
  assign dst_hi = dst_used && (dst_lin >= CELLS_L);
  assign clearing = (state == wgcs_pkg::BK_CLEAR);

  assign read_kind = res.kind;
  assign read_payload = res.payload;
  assign is_free = res.free;
  assign wrote = res.wrote;

  always_comb begin
    state_next = state;
    phase_next = phase;
    src_lin_next = src_lin;
    dst_lin_next = dst_lin;
    clr_addr_next = clr_addr;
    q_pop = 1'b0;
    ram_raddr = src_lin[AW-1:0];
    ram_waddr = dst_lin[AW-1:0];
    t_we = 1'b0;
    p_we = 1'b0;
    t_wdata = ck;
    p_wdata = pl;
    res_load = 1'b0;
    res_next = '0;

    case (state)
      wgcs_pkg::BK_CLEAR: begin
        ram_waddr = clr_addr;
        t_we = 1'b1;
        p_we = 1'b1;
        t_wdata = '0;
        p_wdata = '0;
        if (clr_addr == AW'(CELLS - 1)) begin
          state_next = wgcs_pkg::BK_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      wgcs_pkg::BK_IDLE: begin
        if (!q_empty && !out_valid) begin
          q_pop = 1'b1;
          src_lin_next = head_src_lin;
          dst_lin_next = head_dst_lin;
          phase_next = 1'b0;
          state_next = wgcs_pkg::BK_ISSUE;
        end
      end
      wgcs_pkg::BK_ISSUE: begin
        // Rows beyond a small grid alias onto later columns; fold the index
        // back into the store one subtraction at a time.
        if (src_hi || dst_hi) begin
          if (src_hi) src_lin_next = src_lin - CELLS_L;
          if (dst_hi) dst_lin_next = dst_lin - CELLS_L;
        end else begin
          case (op)
            wgcs_pkg::OP_WRITE: begin
              t_we = 1'b1;
              p_we = 1'b1;
              res_load = 1'b1;
              res_next.wrote = 1'b1;
              state_next = wgcs_pkg::BK_IDLE;
            end
            wgcs_pkg::OP_CLEAR: begin
              t_we = 1'b1;
              t_wdata = '0;
              res_load = 1'b1;
              res_next.wrote = 1'b1;
              state_next = wgcs_pkg::BK_IDLE;
            end
            wgcs_pkg::OP_GET, wgcs_pkg::OP_MOVE_DIR: begin
              state_next = wgcs_pkg::BK_DATA;
            end
            wgcs_pkg::OP_TEST, wgcs_pkg::OP_MOVE_PT: begin
              ram_raddr = dst_lin[AW-1:0];
              state_next = wgcs_pkg::BK_DATA;
            end
            default: begin
              res_load = 1'b1;
              state_next = wgcs_pkg::BK_IDLE;
            end
          endcase
        end
      end
      wgcs_pkg::BK_DATA: begin
        state_next = wgcs_pkg::BK_IDLE;
        case (op)
          wgcs_pkg::OP_GET: begin
            res_load = 1'b1;
            res_next.kind = t_rdata;
            res_next.payload = p_rdata;
          end
          wgcs_pkg::OP_TEST: begin
            res_load = 1'b1;
            res_next.free = (t_rdata == 2'd0);
          end
          wgcs_pkg::OP_MOVE_DIR: begin
            t_we = 1'b1;
            p_we = 1'b1;
            t_wdata = t_rdata;
            p_wdata = p_rdata;
            res_load = 1'b1;
            res_next.wrote = 1'b1;
          end
          wgcs_pkg::OP_MOVE_PT: begin
            if (!phase) begin
              // First read was the target; go on to the source only if it is empty.
              if (t_rdata != 2'd0) begin
                res_load = 1'b1;
              end else begin
                phase_next = 1'b1;
                state_next = wgcs_pkg::BK_DATA;
              end
            end else begin
              t_we = (t_rdata != 2'd0);
              p_we = (t_rdata != 2'd0);
              t_wdata = t_rdata;
              p_wdata = p_rdata;
              res_load = 1'b1;
              res_next.wrote = (t_rdata != 2'd0);
            end
          end
          default: begin
            res_load = 1'b1;
          end
        endcase
      end
      default: begin
        state_next = wgcs_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wgcs_pkg::BK_CLEAR;
      clr_addr <= '0;
      phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      clr_addr <= clr_addr_next;
      phase <= phase_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_lin <= src_lin_next;
    dst_lin <= dst_lin_next;
    if (q_pop) begin
      op <= q_head.op;
      ck <= q_head.cell_kind;
      pl <= q_head.payload;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !out_valid)
    else $error("result loaded while previous result still waiting");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == wgcs_pkg::BK_CLEAR) |-> !q_pop)
    else $error("command taken during clearing pass");

  a_pop_then_issue: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == wgcs_pkg::BK_ISSUE))
    else $error("popped command not issued");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == wgcs_pkg::BK_IDLE) |-> !(t_we || p_we))
    else $error("cell memory written while idle");

endmodule

`default_nettype wire

/* sv/wrapped_grid_cell_store.sv */
// A result is registered after its item passes the command queue and the
// sequencer's idle and issue states; gets, tests and moves add its data state,
// which a move to point revisits for the source when the target is empty. The
// sequencer steps through its memory reads and takes the next item only after
// the previous result has been taken. A MAX_WIDTH or MAX_HEIGHT below 100 keeps
// it in the issue state while it folds an index. Reset clears control state and then
// zeroes all MAX_WIDTH*MAX_HEIGHT cells, one per cycle, while in_ready is low.
`default_nettype none

module wrapped_grid_cell_store #(
  parameter int MAX_WIDTH = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         kind,
  input  logic signed [8:0]  x_coord,
  input  logic signed [8:0]  y_coord,
  input  logic [2:0]         direction,
  input  logic [1:0]         cell_kind,
  input  logic [31:0]        payload,
  input  logic signed [8:0]  target_x,
  input  logic signed [8:0]  target_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         read_kind,
  output logic [31:0]        read_payload,
  output logic               is_free,
  output logic               wrote
);

  localparam logic [10:0] MAXW_L = 11'(MAX_WIDTH);
  localparam logic [10:0] MAXH_L = 11'(MAX_HEIGHT);

  logic [7:0] grid_width;
  logic [7:0] grid_height;

  wgcs_pkg::cmd_t front_cmd;
  wgcs_pkg::cmd_t q_head;
  logic q_full, q_empty, q_pop, q_push, clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= wgcs_pkg::DEFAULT_SIZE;
      grid_height <= wgcs_pkg::DEFAULT_SIZE;
    end else if (cfg_write) begin
      case (cfg_index)
        wgcs_pkg::REG_GRID_WIDTH:  grid_width <= wgcs_pkg::size_sel(cfg_data, MAXW_L);
        wgcs_pkg::REG_GRID_HEIGHT: grid_height <= wgcs_pkg::size_sel(cfg_data, MAXH_L);
        default: begin
          grid_width <= grid_width;
        end
      endcase
    end
  end

  assign in_ready = !q_full && !clearing;
  assign q_push = in_valid && in_ready;

  wgcs_front u_front (
    .kind        (kind),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .direction   (direction),
    .cell_kind   (cell_kind),
    .payload     (payload),
    .target_x    (target_x),
    .target_y    (target_y),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .cmd         (front_cmd)
  );

  wgcs_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  wgcs_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_kind    (read_kind),
    .read_payload (read_payload),
    .is_free      (is_free),
    .wrote        (wrote)
  );

endmodule

`default_nettype wire
